FILE: rtl/blab_pkg.sv
// ----------------------------------------------------------------------------
// blab_pkg
// Types and constants shared by the blob live-block accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package blab_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int BLOCK_SHIFT = 12;

   localparam logic KIND_ADD     = 1'b0;
   localparam logic KIND_FINISH  = 1'b1;
   localparam logic STATUS_ENTRY = 1'b0;
   localparam logic STATUS_FULL  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic        is_blob_index;
      logic [63:0] blob_file;
      logic [63:0] blob_size;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [63:0] entry_file;
      logic [63:0] live_blocks;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key;
      logic [63:0] count;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_DUMP_RD,
      ST_DUMP_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/blob_live_block_accumulator_unit.sv
// ----------------------------------------------------------------------------
// blob_live_block_accumulator_unit
// Sorted table of blob file numbers with saturating 4 KiB block counts.
// ----------------------------------------------------------------------------
// usage:
//   a word on req_word is taken at a clock edge with start high and busy low.
//   an add word that is a blob reference adds blob_size/4096+1 to the count
//   of its file, inserting the file in ascending order if it is new. a finish
//   word reads every entry out in ascending order, last marking the final one.
//   results appear on rsp_word for one cycle with rsp_valid high; the
//   receiver has no way to stall them.
// sequence:
//   all entries live in one synchronous memory with a registered read, so
//   each access has a read state and a use state. an add is accepted in
//   idle, then compares entries from entry 0 (scan read, compare); an
//   insert that moves entries adds a shift read and a shift write per entry
//   moved, then the insert write. an add to an empty table goes straight
//   to the insert write; a finish reads then outputs each entry in turn.
//   non-blob adds and a finish on an empty table never raise busy. a
//   result is registered and shows in the next cycle; busy may be low then.
// reset:
//   synchronous; clears the fill count, no clearing pass over the memory.
// ----------------------------------------------------------------------------
`default_nettype none

module blob_live_block_accumulator_unit (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  wire blab_pkg::req_type req_word,
   output logic              rsp_valid,
   output blab_pkg::rsp_type rsp_word
);
   import blab_pkg::*;

   entry_type        mem [TABLE_ENTRIES];
   entry_type        rdata_ff;
   logic [IDX_W-1:0] raddr;
   logic             mem_we;
   logic [IDX_W-1:0] waddr;
   entry_type        wdata;

   state_type        state_ff, state_in;
   logic [63:0]      file_ff, file_in;
   logic [63:0]      inc_ff, inc_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [64:0]      sum;
   logic [CNT_W-1:0] idx_next_cnt;
   logic [CNT_W-1:0] pos_new;
   logic             key_lt;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      file_ff <= file_in;
      inc_ff  <= inc_in;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      rsp_ff  <= rsp_in;
   end

   assign sum          = {1'b0, rdata_ff.count} + {1'b0, inc_ff};
   assign idx_next_cnt = CNT_W'(idx_ff) + CNT_W'(1);
   assign key_lt       = rdata_ff.key < file_ff;
   assign pos_new      = key_lt ? idx_next_cnt : CNT_W'(idx_ff);

   always_comb begin
      state_in     = state_ff;
      file_in      = file_ff;
      inc_in       = inc_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      used_in      = used_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      raddr        = idx_ff;
      mem_we       = 1'b0;
      waddr        = idx_ff;
      wdata        = rdata_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               file_in = req_word.blob_file;
               inc_in  = (req_word.blob_size >> BLOCK_SHIFT) + 64'd1;
               idx_in  = '0;
               pos_in  = '0;
               if (req_word.kind == KIND_FINISH) begin
                  if (used_ff != '0) begin
                     state_in = ST_DUMP_RD;
                  end
               end else if (req_word.is_blob_index) begin
                  if (used_ff == '0) begin
                     state_in = ST_INSERT;
                  end else begin
                     state_in = ST_SCAN_RD;
                  end
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (rdata_ff.key == file_ff) begin
               mem_we      = 1'b1;
               waddr       = idx_ff;
               wdata.key   = rdata_ff.key;
               wdata.count = sum[64] ? '1 : sum[63:0];
               state_in    = ST_IDLE;
            end else if (key_lt && (idx_next_cnt != used_ff)) begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_SCAN_RD;
            end else if (used_ff == CNT_W'(TABLE_ENTRIES)) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = STATUS_FULL;
               rsp_in.entry_file  = file_ff;
               rsp_in.live_blocks = '0;
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end else if (pos_new == used_ff) begin
               mem_we      = 1'b1;
               waddr       = pos_new[IDX_W-1:0];
               wdata.key   = file_ff;
               wdata.count = inc_ff;
               used_in     = used_ff + CNT_W'(1);
               state_in    = ST_IDLE;
            end else begin
               pos_in   = pos_new[IDX_W-1:0];
               idx_in   = used_ff[IDX_W-1:0];
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            raddr    = idx_ff - IDX_W'(1);
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            mem_we = 1'b1;
            waddr  = idx_ff;
            wdata  = rdata_ff;
            if ((idx_ff - IDX_W'(1)) == pos_ff) begin
               state_in = ST_INSERT;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = ST_SHIFT_RD;
            end
         end
         ST_INSERT: begin
            mem_we      = 1'b1;
            waddr       = pos_ff;
            wdata.key   = file_ff;
            wdata.count = inc_ff;
            used_in     = used_ff + CNT_W'(1);
            state_in    = ST_IDLE;
         end
         ST_DUMP_RD: begin
            state_in = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.status      = STATUS_ENTRY;
            rsp_in.entry_file  = rdata_ff.key;
            rsp_in.live_blocks = rdata_ff.count;
            rsp_in.last        = (idx_next_cnt == used_ff);
            if (idx_next_cnt == used_ff) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_DUMP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // fill count never runs past the table size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("fill count beyond table size");

   // a word only comes out of a compare or readout cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_SCAN_CMP || $past(state_ff) == ST_DUMP_OUT))
      else $error("result without a source state");

   // table-full report only with a full table and as the final word
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_FULL)
         |-> (used_ff == CNT_W'(TABLE_ENTRIES) && rsp_ff.last))
      else $error("table-full report with room left");

   // work starts only from an accepted request
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without a request");

endmodule

`default_nettype wire
